// ===== sv/pbps_pkg.sv =====
`default_nettype none

package pbps_pkg;

    // Width of each configuration register
    localparam int CFG_WIDTH = 24;

    // Register reset values, in ticks
    localparam logic [CFG_WIDTH-1:0] FIRST_PULSE_RESET = 24'd32000;
    localparam logic [CFG_WIDTH-1:0] GAP_RESET         = 24'd3968000;
    localparam logic [CFG_WIDTH-1:0] WAKE_PULSE_RESET  = 24'd200000;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_FIRST_PULSE = 2'd0,
        REG_GAP         = 2'd1,
        REG_WAKE_PULSE  = 2'd2,
        REG_NONE        = 2'd3
    } cfg_index_t;

    // Event kinds
    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_BUTTON = 2'd1,
        MODE_LID    = 2'd2,
        MODE_INIT   = 2'd3
    } mode_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE     = 4'd0,
        S_PRESSED  = 4'd1,
        S_T0       = 4'd2,
        S_T1       = 4'd3,
        S_HELD     = 4'd4,
        S_LID      = 4'd5,
        S_RELEASED = 4'd6,
        S_EAT      = 4'd7,
        S_INITON   = 4'd8,
        S_KBRESET  = 4'd9,
        S_WASOFF   = 4'd10
    } seq_state_t;

endpackage

`default_nettype wire

// ===== sv/power_button_pulse_sequencer.sv =====
`default_nettype none

// Power button pulse sequencer. Each transfer on the input channel carries one
// event (tick, button change, lid change or init) and yields exactly one result
// transfer with the chipset line level, a line-driven flag, a one-item wake
// request, the host button and lid bits, the sequencer state and a timer-busy
// flag. One event is taken every clock cycle while the result channel does not
// stall. The event sits in the input register, and the state update writes the
// result register once the result slot is free. The rate is set by that single
// update stage. When the result register is full and not taken, the input
// register holds and the input stalls. Configuration registers (t0 pulse, t1
// gap, wake pulse, in ticks) are written through their own port; the user must
// write them only while no event is in flight, which the block does not enforce;
// a value that does not fit in TIMER_WIDTH bits loads the timer at its maximum.
module power_button_pulse_sequencer
    import pbps_pkg::*;
#(
    parameter int TIMER_WIDTH = 24
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [CFG_WIDTH-1:0] cfg_data,
    // event channel
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           mode,
    input  wire logic                 button_down,
    input  wire logic                 chipset_off,
    input  wire logic                 chipset_on,
    input  wire logic                 battery_low,
    input  wire logic                 charger_initializing,
    input  wire logic                 lid_open,
    input  wire logic                 jumped_image,
    input  wire logic                 stay_off,
    input  wire logic                 reset_pin_boot,
    // result channel
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      line_high,
    output logic                      line_written,
    output logic                      wake_request,
    output logic                      button_flag,
    output logic                      lid_flag,
    output logic [3:0]                seq_state,
    output logic                      timer_busy
);

    typedef struct packed {
        logic [1:0] mode;
        logic       btn;
        logic       off;
        logic       on;
        logic       batt_low;
        logic       chg_init;
        logic       lid;
        logic       jumped;
        logic       stay;
        logic       pin_boot;
    } event_t;

    // configuration registers
    logic [CFG_WIDTH-1:0]   first_pulse_reg;
    logic [CFG_WIDTH-1:0]   gap_reg;
    logic [CFG_WIDTH-1:0]   wake_pulse_reg;
    logic [TIMER_WIDTH-1:0] first_load;
    logic [TIMER_WIDTH-1:0] gap_load;
    logic [TIMER_WIDTH-1:0] wake_load;

    // input register
    logic   ev_valid_reg;
    event_t ev_reg;
    logic   advance;

    // sequencer state
    seq_state_t             state_reg, state_next;
    logic [TIMER_WIDTH-1:0] ticks_reg, ticks_next;
    logic                   level_reg, level_next;
    logic                   pressed_reg, pressed_next;
    logic                   lid_reg, lid_next;
    logic                   wrote_next;
    logic                   wake_next;

    // result register
    logic out_valid_reg;

    assign cfg_ready = 1'b1;

    // take configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_pulse_reg <= FIRST_PULSE_RESET;
            gap_reg         <= GAP_RESET;
            wake_pulse_reg  <= WAKE_PULSE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                REG_FIRST_PULSE: first_pulse_reg <= cfg_data;
                REG_GAP:         gap_reg         <= cfg_data;
                REG_WAKE_PULSE:  wake_pulse_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // timer load values, saturated to the timer width
    generate
        if (TIMER_WIDTH >= CFG_WIDTH)
        begin : g_load_wide
            assign first_load = TIMER_WIDTH'(first_pulse_reg);
            assign gap_load   = TIMER_WIDTH'(gap_reg);
            assign wake_load  = TIMER_WIDTH'(wake_pulse_reg);
        end
        else
        begin : g_load_narrow
            assign first_load = (|first_pulse_reg[CFG_WIDTH-1:TIMER_WIDTH]) ?
                                {TIMER_WIDTH{1'b1}} : first_pulse_reg[TIMER_WIDTH-1:0];
            assign gap_load   = (|gap_reg[CFG_WIDTH-1:TIMER_WIDTH]) ?
                                {TIMER_WIDTH{1'b1}} : gap_reg[TIMER_WIDTH-1:0];
            assign wake_load  = (|wake_pulse_reg[CFG_WIDTH-1:TIMER_WIDTH]) ?
                                {TIMER_WIDTH{1'b1}} : wake_pulse_reg[TIMER_WIDTH-1:0];
        end
    endgenerate

    // the update stage advances when an event waits and the result slot is free
    assign advance  = ev_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !ev_valid_reg || advance;

    // hold the accepted event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            ev_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ev_reg <= '{mode: mode, btn: button_down, off: chipset_off, on: chipset_on,
                        batt_low: battery_low, chg_init: charger_initializing,
                        lid: lid_open, jumped: jumped_image, stay: stay_off,
                        pin_boot: reset_pin_boot};
        end
    end

    // apply the event, count down, then make at most one timed transition
    always_comb
    begin
        logic forced;
        state_next   = state_reg;
        ticks_next   = ticks_reg;
        level_next   = level_reg;
        pressed_next = pressed_reg;
        lid_next     = lid_reg;
        wrote_next   = 1'b0;
        wake_next    = 1'b0;
        forced       = (state_reg == S_KBRESET) || (state_reg == S_INITON) ||
                       (state_reg == S_LID) || (state_reg == S_WASOFF);

        case (mode_t'(ev_reg.mode))
            MODE_BUTTON:
            begin
                if (!forced)
                begin
                    if (ev_reg.btn)
                    begin
                        state_next   = S_PRESSED;
                        ticks_next   = '0;
                        pressed_next = 1'b1;
                    end
                    else if (state_reg == S_EAT)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next   = S_RELEASED;
                        ticks_next   = '0;
                        pressed_next = 1'b0;
                    end
                end
            end
            MODE_LID:
            begin
                lid_next = ev_reg.lid;
                if (ev_reg.lid && ev_reg.off)
                begin
                    wake_next  = 1'b1;
                    level_next = ev_reg.batt_low;
                    wrote_next = 1'b1;
                    state_next = S_LID;
                    ticks_next = wake_load;
                end
            end
            MODE_INIT:
            begin
                state_next   = S_IDLE;
                ticks_next   = '0;
                pressed_next = 1'b0;
                lid_next     = ev_reg.lid;
                if (ev_reg.jumped && ev_reg.on)
                begin
                    if (ev_reg.btn)
                    begin
                        pressed_next = 1'b1;
                        level_next   = ev_reg.batt_low;
                        wrote_next   = 1'b1;
                    end
                end
                else if (ev_reg.stay)
                begin
                    level_next = 1'b1;
                    wrote_next = 1'b1;
                    state_next = ev_reg.btn ? S_EAT : S_IDLE;
                end
                else
                begin
                    state_next = S_INITON;
                end
            end
            default:
            begin
                if (ticks_reg != '0)
                begin
                    ticks_next = ticks_reg - 1'b1;
                end
            end
        endcase

        // timed transition once the countdown has run out
        if (ticks_next == '0)
        begin
            case (state_next)
                S_PRESSED:
                begin
                    if (ev_reg.off)
                    begin
                        wake_next  = 1'b1;
                        ticks_next = wake_load;
                        state_next = S_WASOFF;
                    end
                    else
                    begin
                        ticks_next = first_load;
                        state_next = S_T0;
                    end
                    level_next = ev_reg.batt_low;
                    wrote_next = 1'b1;
                end
                S_T0:
                begin
                    ticks_next = gap_load;
                    state_next = S_T1;
                    level_next = 1'b1;
                    wrote_next = 1'b1;
                end
                S_T1:
                begin
                    if (!ev_reg.off)
                    begin
                        level_next = ev_reg.batt_low;
                        wrote_next = 1'b1;
                    end
                    state_next = S_HELD;
                end
                S_RELEASED, S_LID:
                begin
                    level_next = 1'b1;
                    wrote_next = 1'b1;
                    state_next = S_IDLE;
                end
                S_INITON:
                begin
                    if (!ev_reg.chg_init)
                    begin
                        wake_next  = 1'b1;
                        level_next = ev_reg.batt_low;
                        wrote_next = 1'b1;
                        ticks_next = wake_load;
                        if (ev_reg.btn)
                        begin
                            pressed_next = 1'b1;
                            state_next   = ev_reg.pin_boot ? S_KBRESET : S_WASOFF;
                        end
                        else
                        begin
                            state_next = S_RELEASED;
                        end
                    end
                end
                S_KBRESET:
                begin
                    level_next = 1'b1;
                    wrote_next = 1'b1;
                    state_next = ev_reg.btn ? S_EAT : S_IDLE;
                end
                S_WASOFF:
                begin
                    if (ev_reg.btn)
                    begin
                        state_next = S_HELD;
                    end
                    else
                    begin
                        state_next   = S_RELEASED;
                        pressed_next = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // sequencer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ticks_reg   <= '0;
            level_reg   <= 1'b1;
            pressed_reg <= 1'b0;
            lid_reg     <= 1'b0;
        end
        else if (advance)
        begin
            state_reg   <= state_next;
            ticks_reg   <= ticks_next;
            level_reg   <= level_next;
            pressed_reg <= pressed_next;
            lid_reg     <= lid_next;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            line_high    <= level_next;
            line_written <= wrote_next;
            wake_request <= wake_next;
            button_flag  <= pressed_next;
            lid_flag     <= lid_next;
            seq_state    <= state_next;
            timer_busy   <= (ticks_next != '0);
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import pbps_pkg::*;

    // One event as presented on the input channel
    typedef struct packed {
        mode_t mode;
        logic  button_down;
        logic  chipset_off;
        logic  chipset_on;
        logic  battery_low;
        logic  charger_initializing;
        logic  lid_open;
        logic  jumped_image;
        logic  stay_off;
        logic  reset_pin_boot;
    } pb_event_t;

    // What the block reports after each event
    typedef struct packed {
        logic       line_high;
        logic       line_written;
        logic       wake_request;
        logic       button_flag;
        logic       lid_flag;
        seq_state_t seq_state;
        logic       timer_busy;
    } line_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [1:0]           cfg_index;
    logic [CFG_WIDTH-1:0] cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           mode;
    logic                 button_down;
    logic                 chipset_off;
    logic                 chipset_on;
    logic                 battery_low;
    logic                 charger_initializing;
    logic                 lid_open;
    logic                 jumped_image;
    logic                 stay_off;
    logic                 reset_pin_boot;
    logic                 out_valid;
    logic                 out_ready;
    logic                 line_high;
    logic                 line_written;
    logic                 wake_request;
    logic                 button_flag;
    logic                 lid_flag;
    logic [3:0]           seq_state;
    logic                 timer_busy;

    // Shadow copy of the sequencer and its timing registers
    logic [CFG_WIDTH-1:0] first_pulse_len;
    logic [CFG_WIDTH-1:0] gap_len;
    logic [CFG_WIDTH-1:0] wake_pulse_len;
    seq_state_t           shadow_state;
    logic [CFG_WIDTH-1:0] shadow_ticks;
    logic                 shadow_line;
    logic                 shadow_pressed;
    logic                 shadow_lid;

    line_result_t expected_lines[$];
    int           mismatch_count;
    int           events_sent;
    logic         steady;

    power_button_pulse_sequencer dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .mode                 (mode),
        .button_down          (button_down),
        .chipset_off          (chipset_off),
        .chipset_on           (chipset_on),
        .battery_low          (battery_low),
        .charger_initializing (charger_initializing),
        .lid_open             (lid_open),
        .jumped_image         (jumped_image),
        .stay_off             (stay_off),
        .reset_pin_boot       (reset_pin_boot),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .line_high            (line_high),
        .line_written         (line_written),
        .wake_request         (wake_request),
        .button_flag          (button_flag),
        .lid_flag             (lid_flag),
        .seq_state            (seq_state),
        .timer_busy           (timer_busy)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result channel at random, except during a steady stretch
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 10);
        end
    end

    // Apply one event to the shadow sequencer and return the expected result
    function automatic line_result_t advance_sequencer(pb_event_t ev);
        logic         wrote;
        logic         wake;
        line_result_t r;
        wrote = 1'b0;
        wake  = 1'b0;

        case (ev.mode)
            MODE_BUTTON:
            begin
                if (!(shadow_state inside {S_KBRESET, S_INITON, S_LID, S_WASOFF}))
                begin
                    if (ev.button_down)
                    begin
                        shadow_state   = S_PRESSED;
                        shadow_ticks   = '0;
                        shadow_pressed = 1'b1;
                    end
                    else if (shadow_state == S_EAT)
                    begin
                        shadow_state = S_IDLE;
                    end
                    else
                    begin
                        shadow_state   = S_RELEASED;
                        shadow_ticks   = '0;
                        shadow_pressed = 1'b0;
                    end
                end
            end
            MODE_LID:
            begin
                shadow_lid = ev.lid_open;
                if (ev.lid_open && ev.chipset_off)
                begin
                    wake         = 1'b1;
                    shadow_line  = ev.battery_low;
                    wrote        = 1'b1;
                    shadow_state = S_LID;
                    shadow_ticks = wake_pulse_len;
                end
            end
            MODE_INIT:
            begin
                shadow_state   = S_IDLE;
                shadow_ticks   = '0;
                shadow_pressed = 1'b0;
                shadow_lid     = ev.lid_open;
                if (ev.jumped_image && ev.chipset_on)
                begin
                    if (ev.button_down)
                    begin
                        shadow_pressed = 1'b1;
                        shadow_line    = ev.battery_low;
                        wrote          = 1'b1;
                    end
                end
                else if (ev.stay_off)
                begin
                    shadow_line  = 1'b1;
                    wrote        = 1'b1;
                    shadow_state = ev.button_down ? S_EAT : S_IDLE;
                end
                else
                begin
                    shadow_state = S_INITON;
                end
            end
            default:
            begin
                if (shadow_ticks != '0)
                    shadow_ticks = shadow_ticks - 1'b1;
            end
        endcase

        // Timed transition once the countdown has run out
        if (shadow_ticks == '0)
        begin
            case (shadow_state)
                S_PRESSED:
                begin
                    if (ev.chipset_off)
                    begin
                        wake         = 1'b1;
                        shadow_ticks = wake_pulse_len;
                        shadow_state = S_WASOFF;
                    end
                    else
                    begin
                        shadow_ticks = first_pulse_len;
                        shadow_state = S_T0;
                    end
                    shadow_line = ev.battery_low;
                    wrote       = 1'b1;
                end
                S_T0:
                begin
                    shadow_ticks = gap_len;
                    shadow_state = S_T1;
                    shadow_line  = 1'b1;
                    wrote        = 1'b1;
                end
                S_T1:
                begin
                    if (!ev.chipset_off)
                    begin
                        shadow_line = ev.battery_low;
                        wrote       = 1'b1;
                    end
                    shadow_state = S_HELD;
                end
                S_RELEASED, S_LID:
                begin
                    shadow_line  = 1'b1;
                    wrote        = 1'b1;
                    shadow_state = S_IDLE;
                end
                S_INITON:
                begin
                    if (!ev.charger_initializing)
                    begin
                        wake         = 1'b1;
                        shadow_line  = ev.battery_low;
                        wrote        = 1'b1;
                        shadow_ticks = wake_pulse_len;
                        if (ev.button_down)
                        begin
                            shadow_pressed = 1'b1;
                            shadow_state   = ev.reset_pin_boot ? S_KBRESET : S_WASOFF;
                        end
                        else
                        begin
                            shadow_state = S_RELEASED;
                        end
                    end
                end
                S_KBRESET:
                begin
                    shadow_line  = 1'b1;
                    wrote        = 1'b1;
                    shadow_state = ev.button_down ? S_EAT : S_IDLE;
                end
                S_WASOFF:
                begin
                    if (ev.button_down)
                    begin
                        shadow_state = S_HELD;
                    end
                    else
                    begin
                        shadow_state   = S_RELEASED;
                        shadow_pressed = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        r.line_high    = shadow_line;
        r.line_written = wrote;
        r.wake_request = wake;
        r.button_flag  = shadow_pressed;
        r.lid_flag     = shadow_lid;
        r.seq_state    = shadow_state;
        r.timer_busy   = (shadow_ticks != '0);
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            mismatch_count++;
            if (mismatch_count <= 100)
                $display("%0t: %s mismatch, expected %0d actual %0d",
                         $time, name, exp_val, act_val);
        end
    endtask

    // Compare every result transfer with the oldest expectation
    always @(posedge clk)
    begin
        line_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_lines.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result transfer with no expectation, expected none actual state %0d",
                         $time, seq_state);
            end
            else
            begin
                want = expected_lines.pop_front();
                check_field("line_high", want.line_high, line_high);
                check_field("line_written", want.line_written, line_written);
                check_field("wake_request", want.wake_request, wake_request);
                check_field("button_flag", want.button_flag, button_flag);
                check_field("lid_flag", want.lid_flag, lid_flag);
                check_field("seq_state", want.seq_state, seq_state);
                check_field("timer_busy", want.timer_busy, timer_busy);
            end
        end
    end

    // Present one event, hold it until the transfer, then maybe idle a while
    task automatic send_event(input pb_event_t ev);
        int gap;
        @(negedge clk);
        mode                 <= ev.mode;
        button_down          <= ev.button_down;
        chipset_off          <= ev.chipset_off;
        chipset_on           <= ev.chipset_on;
        battery_low          <= ev.battery_low;
        charger_initializing <= ev.charger_initializing;
        lid_open             <= ev.lid_open;
        jumped_image         <= ev.jumped_image;
        stay_off             <= ev.stay_off;
        reset_pin_boot       <= ev.reset_pin_boot;
        in_valid             <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        expected_lines.push_back(advance_sequencer(ev));
        events_sent++;
        if (!steady && $urandom_range(0, 99) < 4)
        begin
            gap = $urandom_range(0, 4);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Drop valid and wait until every result is back and the pipeline is empty
    task automatic drain_events();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_lines.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_WIDTH-1:0] value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_FIRST_PULSE: first_pulse_len = value;
            REG_GAP:         gap_len         = value;
            REG_WAKE_PULSE:  wake_pulse_len  = value;
            default:         ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_timing(input logic [CFG_WIDTH-1:0] first_len,
                              input logic [CFG_WIDTH-1:0] gap_value,
                              input logic [CFG_WIDTH-1:0] wake_len);
        drain_events();
        write_reg(REG_FIRST_PULSE, first_len);
        write_reg(REG_GAP, gap_value);
        write_reg(REG_WAKE_PULSE, wake_len);
    endtask

    function automatic pb_event_t plain_event(input mode_t m, input logic btn,
                                              input logic off, input logic batt);
        pb_event_t ev;
        ev             = '0;
        ev.mode        = m;
        ev.button_down = btn;
        ev.chipset_off = off;
        ev.battery_low = batt;
        return ev;
    endfunction

    // Boot paths: button reflected, release eaten, forced power-on pulse
    task automatic test_init_paths();
        pb_event_t ev;
        set_timing(24'd2, 24'd3, 24'd2);
        // unused index must leave the timing alone
        write_reg(REG_NONE, 24'hFFFFFF);

        ev = plain_event(MODE_INIT, 1'b1, 1'b0, 1'b0);
        ev.jumped_image = 1'b1;
        ev.chipset_on   = 1'b1;
        ev.lid_open     = 1'b1;
        send_event(ev);
        ev = plain_event(MODE_INIT, 1'b1, 1'b1, 1'b0);
        ev.stay_off = 1'b1;
        send_event(ev);
        // release in eat goes idle without touching the line
        send_event(plain_event(MODE_BUTTON, 1'b0, 1'b1, 1'b0));
        // init-on waits while the charger is initialising
        ev = plain_event(MODE_INIT, 1'b1, 1'b1, 1'b0);
        ev.charger_initializing = 1'b1;
        send_event(ev);
        ev = plain_event(MODE_TICK, 1'b1, 1'b1, 1'b0);
        ev.charger_initializing = 1'b1;
        send_event(ev);
        ev = plain_event(MODE_TICK, 1'b1, 1'b1, 1'b0);
        ev.reset_pin_boot = 1'b1;
        send_event(ev);
        // button ignored during the keyboard-reset pulse
        send_event(plain_event(MODE_BUTTON, 1'b0, 1'b1, 1'b0));
        send_event(plain_event(MODE_TICK, 1'b1, 1'b1, 1'b0));
        send_event(plain_event(MODE_TICK, 1'b1, 1'b1, 1'b0));
        send_event(plain_event(MODE_BUTTON, 1'b0, 1'b1, 1'b0));
    endtask

    // Press on a running chipset: t0 pulse, t1 gap, held; then a low-battery wake
    task automatic test_press_on_running();
        pb_event_t ev;
        ev = plain_event(MODE_INIT, 1'b0, 1'b0, 1'b0);
        ev.jumped_image = 1'b1;
        ev.chipset_on   = 1'b1;
        send_event(ev);
        send_event(plain_event(MODE_BUTTON, 1'b1, 1'b0, 1'b0));
        repeat (2) send_event(plain_event(MODE_TICK, 1'b1, 1'b0, 1'b0));
        repeat (3) send_event(plain_event(MODE_TICK, 1'b1, 1'b0, 1'b0));
        send_event(plain_event(MODE_BUTTON, 1'b0, 1'b0, 1'b0));
        send_event(plain_event(MODE_BUTTON, 1'b1, 1'b1, 1'b1));
        repeat (2) send_event(plain_event(MODE_TICK, 1'b0, 1'b1, 1'b1));
    endtask

    // Lid opening on an off chipset gives a wake pulse
    task automatic test_wake_and_lid();
        pb_event_t ev;
        ev = plain_event(MODE_LID, 1'b0, 1'b1, 1'b0);
        ev.lid_open = 1'b1;
        send_event(ev);
        send_event(plain_event(MODE_BUTTON, 1'b1, 1'b1, 1'b0));
        repeat (2) send_event(plain_event(MODE_TICK, 1'b0, 1'b1, 1'b0));
        send_event(plain_event(MODE_LID, 1'b0, 1'b0, 1'b0));
    endtask

    function automatic pb_event_t random_event(input logic off_bias, input int batt_pct,
                                               input int chg_pct);
        pb_event_t ev;
        int        pick;
        ev   = pb_event_t'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 60)
            ev.mode = MODE_TICK;
        else if (pick < 82)
            ev.mode = MODE_BUTTON;
        else if (pick < 95)
            ev.mode = MODE_LID;
        else
            ev.mode = MODE_INIT;
        if ($urandom_range(0, 99) < 85)
            ev.chipset_off = off_bias;
        ev.battery_low          = ($urandom_range(0, 99) < batt_pct);
        ev.charger_initializing = ($urandom_range(0, 99) < chg_pct);
        return ev;
    endfunction

    // One boot followed by a burst of presses, lid moves and ticks
    task automatic run_episode();
        pb_event_t ev;
        logic      off_bias;
        int        batt_pct;
        int        chg_pct;
        int        pick;
        int        len;
        off_bias = 1'($urandom_range(0, 1));
        batt_pct = ($urandom_range(0, 3) == 0) ? 50 : 5;
        chg_pct  = $urandom_range(0, 40);
        len      = $urandom_range(5, 30);

        ev   = random_event(off_bias, batt_pct, chg_pct);
        ev.mode = MODE_INIT;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            ev.jumped_image = 1'b1;
            ev.chipset_on   = 1'b1;
        end
        else if (pick < 60)
        begin
            ev.jumped_image = 1'b0;
            ev.stay_off     = 1'b1;
        end
        else if (pick < 95)
        begin
            ev.jumped_image = 1'b0;
            ev.stay_off     = 1'b0;
        end
        send_event(ev);

        repeat (len)
            send_event(random_event(off_bias, batt_pct, chg_pct));
    endtask

    task automatic test_random_sequences(input int count,
                                         input logic [CFG_WIDTH-1:0] first_len,
                                         input logic [CFG_WIDTH-1:0] gap_value,
                                         input logic [CFG_WIDTH-1:0] wake_len,
                                         input logic no_idle);
        int target;
        set_timing(first_len, gap_value, wake_len);
        steady = no_idle;
        target = events_sent + count;
        while (events_sent < target)
            run_episode();
        steady = 1'b0;
    endtask

    // Limit on the whole run
    initial
    begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n                = 1'b0;
        cfg_valid            = 1'b0;
        cfg_index            = REG_FIRST_PULSE;
        cfg_data             = '0;
        in_valid             = 1'b0;
        mode                 = MODE_TICK;
        button_down          = 1'b0;
        chipset_off          = 1'b0;
        chipset_on           = 1'b0;
        battery_low          = 1'b0;
        charger_initializing = 1'b0;
        lid_open             = 1'b0;
        jumped_image         = 1'b0;
        stay_off             = 1'b0;
        reset_pin_boot       = 1'b0;
        steady               = 1'b0;
        mismatch_count       = 0;
        events_sent          = 0;
        first_pulse_len      = FIRST_PULSE_RESET;
        gap_len              = GAP_RESET;
        wake_pulse_len       = WAKE_PULSE_RESET;
        shadow_state         = S_IDLE;
        shadow_ticks         = '0;
        shadow_line          = 1'b1;
        shadow_pressed       = 1'b0;
        shadow_lid           = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // a couple of events under the reset timing first
        send_event(plain_event(MODE_LID, 1'b0, 1'b0, 1'b0));
        send_event(plain_event(MODE_BUTTON, 1'b1, 1'b0, 1'b0));

        test_init_paths();
        test_press_on_running();
        test_wake_and_lid();
        test_random_sequences(300, CFG_WIDTH'($urandom_range(0, 6)),
                              CFG_WIDTH'($urandom_range(0, 6)),
                              CFG_WIDTH'($urandom_range(0, 6)), 1'b1);
        test_random_sequences(200, 24'd0, 24'd0, 24'd0, 1'b0);
        test_random_sequences(400, CFG_WIDTH'($urandom_range(1, 8)),
                              CFG_WIDTH'($urandom_range(0, 8)),
                              CFG_WIDTH'($urandom_range(1, 8)), 1'b0);
        test_random_sequences(150, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
        test_random_sequences(300, 24'hFFFFFF, CFG_WIDTH'($urandom_range(0, 4)),
                              CFG_WIDTH'($urandom_range(0, 4)), 1'b0);
        test_random_sequences(450, CFG_WIDTH'($urandom_range(0, 5)),
                              CFG_WIDTH'($urandom_range(0, 5)),
                              CFG_WIDTH'($urandom_range(0, 5)), 1'b0);

        // Wait for the last results and a little longer
        drain_events();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_lines.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== power_button_pulse_sequencer.f =====
sv/pbps_pkg.sv
sv/power_button_pulse_sequencer.sv
tb/tb_top.sv
